[rtl/lkd_pkg.sv]
// Shared types and constants for the ladder keypad debouncer.
`timescale 1ns / 1ps

package lkd_pkg;

  // Key state layout: ladder A keys 0..3, ladder B keys 4..5, power key 6
  localparam int KEY_BITS  = 7;
  localparam int POWER_KEY = 6;
  localparam int TIME_BITS = 32;
  localparam int DEB_BITS  = 16;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_NO_BUTTON = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_FIRST   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_SECOND  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_THIRD   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_B_SPLIT   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE  = 3'd5;

  // Threshold slots and their reset values
  localparam int NUM_THR   = 5;
  localparam int THR_NONE  = 0;
  localparam int THR_A1    = 1;
  localparam int THR_A2    = 2;
  localparam int THR_A3    = 3;
  localparam int THR_B     = 4;
  localparam int RST_NO_BUTTON = 3800;
  localparam int RST_A_FIRST   = 3100;
  localparam int RST_A_SECOND  = 2090;
  localparam int RST_A_THIRD   = 750;
  localparam int RST_B_SPLIT   = 1120;
  localparam int RST_DEBOUNCE  = 5;
  localparam int RST_THR_BITS  = 12;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  // Classified sample handed from front to back
  typedef struct packed {
    logic [TIME_BITS-1:0] time_ms;
    logic [KEY_BITS-1:0]  raw_keys;
  } key_item_t;

  // Result item, held_keys in the lowest bits
  typedef struct packed {
    logic [TIME_BITS-1:0] power_held_ms;
    logic [TIME_BITS-1:0] any_held_ms;
    logic [KEY_BITS-1:0]  release_events;
    logic [KEY_BITS-1:0]  press_events;
    logic [KEY_BITS-1:0]  held_keys;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);
  localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

[rtl/ladder_keypad_debouncer.sv]
// Top level of the resistor-ladder keypad decoder with debounce.
//
//   channel   dir  handshake                 content
//   s_axis    in   s_tvalid / s_tready       one ADC sample with timestamp
//   m_axis    out  m_tvalid / m_tready       debounced state, events, hold times
//   cfg       in   cfg_we                    thresholds and debounce time
//
// One item per cycle sustained while m_tready stays high; the result passes through
// the decode register (loaded on the accepting edge), then the queue, then the result register.
// The debounce state update and hold-time subtractions are combinational in
// the back stage, which sets the rate.
// rst clears all key state, timers, queue and configuration to reset values.
// Either side may stall; the two-entry queue absorbs back-pressure.
`timescale 1ns / 1ps

module ladder_keypad_debouncer #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // ladder_a_sample, ladder_b_sample, power_pin_level, time_ms, zero pad
  input  logic [((2*SAMPLE_BITS+33+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // held_keys, press_events, release_events, any_held_ms, power_held_ms, zero pad
  output logic [lkd_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  input  logic                                  cfg_we,
  input  logic [lkd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [lkd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import lkd_pkg::*;

  localparam int THR_BITS = (SAMPLE_BITS > RST_THR_BITS) ? SAMPLE_BITS : RST_THR_BITS;
  localparam int PIN_BIT  = 2 * SAMPLE_BITS;

  logic [NUM_THR-1:0][THR_BITS-1:0] thresholds;
  logic [DEB_BITS-1:0]              debounce_ms;
  logic [THR_BITS-1:0]              cfg_thr;

  logic      f_valid;
  logic      f_ready;
  key_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  key_item_t q_item;
  result_t   result;

  assign cfg_thr = THR_BITS'(cfg_data[SAMPLE_BITS-1:0]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds[THR_NONE] <= THR_BITS'(RST_NO_BUTTON);
      thresholds[THR_A1]   <= THR_BITS'(RST_A_FIRST);
      thresholds[THR_A2]   <= THR_BITS'(RST_A_SECOND);
      thresholds[THR_A3]   <= THR_BITS'(RST_A_THIRD);
      thresholds[THR_B]    <= THR_BITS'(RST_B_SPLIT);
      debounce_ms          <= DEB_BITS'(RST_DEBOUNCE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NO_BUTTON: thresholds[THR_NONE] <= cfg_thr;
        REG_A_FIRST:   thresholds[THR_A1]   <= cfg_thr;
        REG_A_SECOND:  thresholds[THR_A2]   <= cfg_thr;
        REG_A_THIRD:   thresholds[THR_A3]   <= cfg_thr;
        REG_B_SPLIT:   thresholds[THR_B]    <= cfg_thr;
        REG_DEBOUNCE:  debounce_ms          <= cfg_data[DEB_BITS-1:0];
        default: ;
      endcase
    end
  end

  lkd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .THR_BITS    (THR_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .ladder_a_sample (s_tdata[SAMPLE_BITS-1:0]),
    .ladder_b_sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .power_pin_level (s_tdata[PIN_BIT]),
    .time_ms         (s_tdata[PIN_BIT+TIME_BITS:PIN_BIT+1]),
    .thresholds      (thresholds),
    .out_valid       (f_valid),
    .out_ready       (f_ready),
    .out_item        (f_item)
  );

  lkd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  lkd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_item     (q_item),
    .debounce_ms (debounce_ms),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (result)
  );

  assign m_tdata = OUT_TDATA_BITS'(result);

endmodule

[rtl/lkd_front.sv]
// Front stage: decodes the ladder readings into a raw key state and registers it.
`timescale 1ns / 1ps

module lkd_front #(
  parameter int SAMPLE_BITS = 12,
  parameter int THR_BITS    = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [SAMPLE_BITS-1:0]                   ladder_a_sample,
  input  logic [SAMPLE_BITS-1:0]                   ladder_b_sample,
  input  logic                                     power_pin_level,
  input  logic [lkd_pkg::TIME_BITS-1:0]            time_ms,
  input  logic [lkd_pkg::NUM_THR-1:0][THR_BITS-1:0] thresholds,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output lkd_pkg::key_item_t                       out_item
);
  import lkd_pkg::*;

  logic [THR_BITS-1:0] a_val;
  logic [THR_BITS-1:0] b_val;
  logic [3:0]          a_keys;
  logic [1:0]          b_keys;
  key_item_t           item_next;

  assign a_val = THR_BITS'(ladder_a_sample);
  assign b_val = THR_BITS'(ladder_b_sample);

  // Ladder A: first matching band wins
  always_comb begin
    priority if (a_val > thresholds[THR_A1] && a_val <= thresholds[THR_NONE]) begin
      a_keys = 4'b0001;
    end else if (a_val > thresholds[THR_A2] && a_val <= thresholds[THR_A1]) begin
      a_keys = 4'b0010;
    end else if (a_val > thresholds[THR_A3] && a_val <= thresholds[THR_A2]) begin
      a_keys = 4'b0100;
    end else if (a_val <= thresholds[THR_A3]) begin
      a_keys = 4'b1000;
    end else begin
      a_keys = 4'b0000;
    end
  end

  // Ladder B
  always_comb begin
    priority if (b_val > thresholds[THR_B] && b_val <= thresholds[THR_NONE]) begin
      b_keys = 2'b01;
    end else if (b_val <= thresholds[THR_B]) begin
      b_keys = 2'b10;
    end else begin
      b_keys = 2'b00;
    end
  end

  assign item_next.raw_keys = {~power_pin_level, b_keys, a_keys};
  assign item_next.time_ms  = time_ms;

  assign in_ready = !out_valid || out_ready;

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

[rtl/lkd_queue.sv]
// Two-entry queue between the decode front and the debounce back.
`timescale 1ns / 1ps

module lkd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  lkd_pkg::key_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output lkd_pkg::key_item_t pop_item
);
  import lkd_pkg::*;

  key_item_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/lkd_back.sv]
// Back stage: debounce state, hold timers and the result register.
`timescale 1ns / 1ps

module lkd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lkd_pkg::key_item_t             in_item,
  input  logic [lkd_pkg::DEB_BITS-1:0]   debounce_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lkd_pkg::result_t               out_result
);
  import lkd_pkg::*;

  logic [KEY_BITS-1:0]  raw_last;
  logic [KEY_BITS-1:0]  stable_keys;
  logic [TIME_BITS-1:0] change_time;
  logic [TIME_BITS-1:0] hold_start;
  logic [TIME_BITS-1:0] hold_finish;
  logic [TIME_BITS-1:0] power_start;
  logic [TIME_BITS-1:0] power_finish;

  logic [KEY_BITS-1:0]  raw;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] elapsed;
  logic                 fire;
  logic                 take;
  logic [KEY_BITS-1:0]  pressed;
  logic [KEY_BITS-1:0]  released;
  logic [KEY_BITS-1:0]  stable_next;
  logic [TIME_BITS-1:0] hold_start_next;
  logic [TIME_BITS-1:0] hold_finish_next;
  logic [TIME_BITS-1:0] power_start_next;
  logic [TIME_BITS-1:0] power_finish_next;
  result_t              result_next;

  assign raw      = in_item.raw_keys;
  assign now      = in_item.time_ms;
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Debounce decision; a fresh change restarts the stability window at zero
  always_comb begin
    elapsed  = (raw != raw_last) ? '0 : now - change_time;
    fire     = (elapsed > TIME_BITS'(debounce_ms)) && (raw != stable_keys);
    pressed  = fire ? (raw & ~stable_keys) : '0;
    released = fire ? (stable_keys & ~raw) : '0;
    stable_next = fire ? raw : stable_keys;
    hold_start_next   = (pressed != '0 && stable_keys == '0) ? now : hold_start;
    hold_finish_next  = (released != '0 && raw == '0) ? now : hold_finish;
    power_start_next  = pressed[POWER_KEY] ? now : power_start;
    power_finish_next = released[POWER_KEY] ? now : power_finish;
  end

  // Result fields, all differences wrap
  always_comb begin
    result_next.held_keys      = stable_next;
    result_next.press_events   = pressed;
    result_next.release_events = released;
    result_next.any_held_ms    = (stable_next != '0) ? now - hold_start_next
                                                     : hold_finish_next - hold_start_next;
    result_next.power_held_ms  = stable_next[POWER_KEY] ? now - power_start_next
                                                        : power_finish_next - power_start_next;
  end

  // Debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last     <= '0;
      stable_keys  <= '0;
      change_time  <= '0;
      hold_start   <= '0;
      hold_finish  <= '0;
      power_start  <= '0;
      power_finish <= '0;
    end else if (take) begin
      if (raw != raw_last) begin
        raw_last    <= raw;
        change_time <= now;
      end
      stable_keys  <= stable_next;
      hold_start   <= hold_start_next;
      hold_finish  <= hold_finish_next;
      power_start  <= power_start_next;
      power_finish <= power_finish_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_press_release_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.press_events & out_result.release_events) == '0)
    else $error("press and release events overlap");

  a_press_in_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.press_events & ~out_result.held_keys) == '0)
    else $error("pressed key not in debounced state");

  a_release_not_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.release_events & out_result.held_keys) == '0)
    else $error("released key still in debounced state");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(stable_keys) && $stable(raw_last))
    else $error("debounce state moved without an item");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ladder keypad debouncer: directed, config and random samples.
`timescale 1ns / 1ps

module tb_top;
  import lkd_pkg::*;

  localparam int SAMPLE_W = 12;
  localparam int IN_W     = ((2*SAMPLE_W+33+7)/8)*8;

  // One ADC sample as packed on s_tdata, ladder A in the lowest bits
  typedef struct packed {
    logic [31:0]         t_ms;
    logic                pin;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] a;
  } adc_sample_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_W-1:0]           s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  ladder_keypad_debouncer #(.SAMPLE_BITS(SAMPLE_W)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the thresholds and debounce time
  logic [SAMPLE_W-1:0] lvl_none = 12'(RST_NO_BUTTON);
  logic [SAMPLE_W-1:0] lvl_a1   = 12'(RST_A_FIRST);
  logic [SAMPLE_W-1:0] lvl_a2   = 12'(RST_A_SECOND);
  logic [SAMPLE_W-1:0] lvl_a3   = 12'(RST_A_THIRD);
  logic [SAMPLE_W-1:0] lvl_b    = 12'(RST_B_SPLIT);
  logic [15:0]         deb_ms   = 16'(RST_DEBOUNCE);

  // Predictor copy of the key and timer state
  logic [KEY_BITS-1:0] raw_prev   = '0;
  logic [KEY_BITS-1:0] stable     = '0;
  logic [31:0]         t_change   = '0;
  logic [31:0]         t_hold_on  = '0;
  logic [31:0]         t_hold_off = '0;
  logic [31:0]         t_pwr_on   = '0;
  logic [31:0]         t_pwr_off  = '0;

  result_t     pending_results[$];
  result_t     got_res;
  result_t     want_res;
  int          mismatches = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          rx_hold_req = 0;
  logic [31:0] stim_ms = 32'd100;

  // Decode, debounce and hold timing for one sample; updates the predictor state
  function automatic result_t predict_keypad(adc_sample_t smp);
    logic [KEY_BITS-1:0] raw;
    logic [KEY_BITS-1:0] pressed;
    logic [KEY_BITS-1:0] released;
    logic [31:0]         since;
    result_t             r;
    raw = '0;
    pressed = '0;
    released = '0;
    // Ladder A, first match wins even with misordered thresholds
    if (smp.a > lvl_a1 && smp.a <= lvl_none) raw[0] = 1'b1;
    else if (smp.a > lvl_a2 && smp.a <= lvl_a1) raw[1] = 1'b1;
    else if (smp.a > lvl_a3 && smp.a <= lvl_a2) raw[2] = 1'b1;
    else if (smp.a <= lvl_a3) raw[3] = 1'b1;
    // Ladder B
    if (smp.b > lvl_b && smp.b <= lvl_none) raw[4] = 1'b1;
    else if (smp.b <= lvl_b) raw[5] = 1'b1;
    raw[POWER_KEY] = ~smp.pin;

    if (raw != raw_prev) begin
      t_change = smp.t_ms;
      raw_prev = raw;
    end
    since = smp.t_ms - t_change;
    if (since > {16'd0, deb_ms} && raw != stable) begin
      pressed  = raw & ~stable;
      released = stable & ~raw;
      if (pressed != 0 && stable == 0) t_hold_on = smp.t_ms;
      if (released != 0 && raw == 0) t_hold_off = smp.t_ms;
      if (pressed[POWER_KEY]) t_pwr_on = smp.t_ms;
      if (released[POWER_KEY]) t_pwr_off = smp.t_ms;
      stable = raw;
    end

    r.held_keys      = stable;
    r.press_events   = pressed;
    r.release_events = released;
    r.any_held_ms    = (stable != 0) ? smp.t_ms - t_hold_on : t_hold_off - t_hold_on;
    r.power_held_ms  = stable[POWER_KEY] ? smp.t_ms - t_pwr_on : t_pwr_off - t_pwr_on;
    return r;
  endfunction

  // Input side: predict on every accepted sample
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      pending_results.push_back(predict_keypad(adc_sample_t'(s_tdata[$bits(adc_sample_t)-1:0])));
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Output side: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = result_t'(m_tdata[RESULT_BITS-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(got_res.held_keys), '0);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.held_keys != want_res.held_keys)
          report_mismatch("held_keys", 32'(got_res.held_keys), 32'(want_res.held_keys));
        if (got_res.press_events != want_res.press_events)
          report_mismatch("press_events", 32'(got_res.press_events),
                          32'(want_res.press_events));
        if (got_res.release_events != want_res.release_events)
          report_mismatch("release_events", 32'(got_res.release_events),
                          32'(want_res.release_events));
        if (got_res.any_held_ms != want_res.any_held_ms)
          report_mismatch("any_held_ms", got_res.any_held_ms, want_res.any_held_ms);
        if (got_res.power_held_ms != want_res.power_held_ms)
          report_mismatch("power_held_ms", got_res.power_held_ms, want_res.power_held_ms);
      end
    end
  end

  // Result sink: random stall per item while rx_idle, plus a long hold-off on request
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 17) : 0;
      if (rx_hold_req != 0) begin
        stall = stall + rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Offer one sample after an optional gap; valid stays high for a back-to-back item
  task automatic send_sample(logic [11:0] a, logic [11:0] b, logic pin, logic [31:0] t);
    int gap;
    adc_sample_t smp;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    smp.a = a;
    smp.b = b;
    smp.pin = pin;
    smp.t_ms = t;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(smp);
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering, wait for every result, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_NO_BUTTON: lvl_none = val[11:0];
      REG_A_FIRST:   lvl_a1   = val[11:0];
      REG_A_SECOND:  lvl_a2   = val[11:0];
      REG_A_THIRD:   lvl_a3   = val[11:0];
      REG_B_SPLIT:   lvl_b    = val[11:0];
      REG_DEBOUNCE:  deb_ms   = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(int none, int a1, int a2, int a3, int b, int deb);
    drain();
    write_reg(REG_NO_BUTTON, 16'(none));
    write_reg(REG_A_FIRST, 16'(a1));
    write_reg(REG_A_SECOND, 16'(a2));
    write_reg(REG_A_THIRD, 16'(a3));
    write_reg(REG_B_SPLIT, 16'(b));
    write_reg(REG_DEBOUNCE, 16'(deb));
  endtask

  // Reading in [lo, hi], or anything when that range is empty
  function automatic logic [11:0] pick_range(int lo, int hi);
    if (lo <= hi) return 12'($urandom_range(hi, lo));
    return 12'($urandom_range(4095, 0));
  endfunction

  // Ladder A reading aimed at key k under the current thresholds; 4 aims at no key
  function automatic logic [11:0] pick_a(int k);
    case (k)
      0:       return pick_range(int'(lvl_a1) + 1, int'(lvl_none));
      1:       return pick_range(int'(lvl_a2) + 1, int'(lvl_a1));
      2:       return pick_range(int'(lvl_a3) + 1, int'(lvl_a2));
      3:       return pick_range(0, int'(lvl_a3));
      default: return pick_range(int'(lvl_none) + 1, 4095);
    endcase
  endfunction

  function automatic logic [11:0] pick_b(int k);
    case (k)
      0:       return pick_range(int'(lvl_b) + 1, int'(lvl_none));
      1:       return pick_range(0, int'(lvl_b));
      default: return pick_range(int'(lvl_none) + 1, 4095);
    endcase
  endfunction

  // Mostly key combinations held across several samples, some noise and time jumps
  task automatic run_samples(int n);
    int left;
    int reps;
    int ka;
    int kb;
    logic pin;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        ka = $urandom_range(0, 4);
        kb = $urandom_range(0, 2);
        pin = 1'($urandom_range(0, 1));
        reps = $urandom_range(1, 6);
        for (int i = 0; i < reps && left > 0; i++) begin
          stim_ms = stim_ms + 32'($urandom_range(0, int'(deb_ms) / 3 + 2));
          send_sample(pick_a(ka), pick_b(kb), pin, stim_ms);
          left--;
        end
      end else begin
        if ($urandom_range(0, 3) == 0) stim_ms = $urandom();
        else stim_ms = stim_ms + 32'($urandom_range(0, 40));
        send_sample(12'($urandom()), 12'($urandom()), 1'($urandom()), stim_ms);
        left--;
      end
    end
  endtask

  // Threshold edges, every key, debounce boundary, time wrap and a short bounce
  task automatic test_directed();
    send_sample(12'd4095, 12'd4095, 1'b1, 32'd100);
    send_sample(12'd3801, 12'd3801, 1'b1, 32'd101);
    send_sample(12'd3800, 12'd4095, 1'b1, 32'd102);
    send_sample(12'd3800, 12'd4095, 1'b1, 32'd107);   // exactly the debounce time: held off
    send_sample(12'd3800, 12'd4095, 1'b1, 32'd108);   // one past: key 0 pressed
    send_sample(12'd3101, 12'd1121, 1'b0, 32'd110);
    send_sample(12'd3101, 12'd1121, 1'b0, 32'd116);
    send_sample(12'd3100, 12'd1120, 1'b0, 32'd117);
    send_sample(12'd3100, 12'd1120, 1'b0, 32'd123);
    send_sample(12'd2091, 12'd0, 1'b1, 32'd124);
    send_sample(12'd2090, 12'd0, 1'b1, 32'd125);
    send_sample(12'd2090, 12'd0, 1'b1, 32'd131);
    send_sample(12'd751, 12'd4095, 1'b1, 32'd132);
    send_sample(12'd750, 12'd4095, 1'b1, 32'd133);
    send_sample(12'd0, 12'd4095, 1'b1, 32'd140);
    // all released across the counter wrap
    send_sample(12'd4095, 12'd4095, 1'b1, 32'hFFFF_FFFD);
    send_sample(12'd4095, 12'd4095, 1'b1, 32'd2);
    send_sample(12'd4095, 12'd4095, 1'b1, 32'd3);
    // power key alone
    send_sample(12'd4095, 12'd4095, 1'b0, 32'd4);
    send_sample(12'd4095, 12'd4095, 1'b0, 32'd10);
    send_sample(12'd4095, 12'd4095, 1'b1, 32'd20);
    send_sample(12'd4095, 12'd4095, 1'b1, 32'd30);
    // bounce shorter than the debounce time is ignored
    send_sample(12'd0, 12'd0, 1'b0, 32'd31);
    send_sample(12'd4095, 12'd4095, 1'b1, 32'd32);
    send_sample(12'd4095, 12'd4095, 1'b1, 32'd40);
    stim_ms = 32'd40;
  endtask

  // Extreme, misordered and random register settings
  task automatic test_thresholds();
    set_thresholds(4095, 3000, 2000, 1000, 2048, 0);
    run_samples(40);
    set_thresholds(0, 0, 0, 0, 0, 65535);
    run_samples(40);
    set_thresholds(2000, 3000, 500, 2500, 4095, 3);
    stim_ms = 32'hFFFF_FF80;
    run_samples(40);
    set_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 20));
    run_samples(40);
  endtask

  // Sink holds off while samples keep coming, so the input side has to stall
  task automatic test_backpressure();
    set_thresholds(RST_NO_BUTTON, RST_A_FIRST, RST_A_SECOND, RST_A_THIRD, RST_B_SPLIT,
                   RST_DEBOUNCE);
    tx_idle = 1'b0;
    rx_hold_req = 90;
    run_samples(30);
    tx_idle = 1'b1;
  endtask

  // Random samples under every mix of source and sink idling
  task automatic test_random();
    for (int mode = 0; mode < 4; mode++) begin
      tx_idle = mode[0];
      rx_idle = mode[1];
      run_samples(50);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/lkd_pkg.sv
rtl/lkd_front.sv
rtl/lkd_queue.sv
rtl/lkd_back.sv
rtl/ladder_keypad_debouncer.sv
tb/tb_top.sv
